// ===== hw/rtl/hkrb_pkg.sv =====
// Shared types, operation codes and the US-layout ASCII table for the
// keyboard report builder. No dependencies.
package hkrb_pkg;

    localparam int DEF_KEY_SLOTS = 6;
    localparam int REPORT_SLOTS  = 6;

    localparam logic [7:0] LSHIFT_MOD     = 8'h02;
    localparam logic [7:0] HID_ENTER      = 8'h28;
    localparam logic [7:0] HID_TAB        = 8'h2B;
    localparam logic [7:0] HID_BKSP       = 8'h2A;
    localparam logic [7:0] HID_ESC        = 8'h29;
    localparam logic [7:0] ASCII_BS       = 8'h08;
    localparam logic [7:0] ASCII_TAB      = 8'h09;
    localparam logic [7:0] ASCII_LF       = 8'h0A;
    localparam logic [7:0] ASCII_CR       = 8'h0D;
    localparam logic [7:0] ASCII_ESC      = 8'h1B;
    localparam logic [7:0] ASCII_PRINT_LO = 8'h20;
    localparam logic [7:0] ASCII_PRINT_HI = 8'h7E;

    typedef enum logic [2:0] {
        OP_PRESS   = 3'd0,
        OP_RELEASE = 3'd1,
        OP_REL_ALL = 3'd2,
        OP_TYPE    = 3'd3,
        OP_TAP     = 3'd4,
        OP_CLEAR   = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_ADD,
        ST_SCAN_DEL,
        ST_SEND,
        ST_HOLD
    } st_t;

    // code[7] flags that left shift is needed, code[6:0] is the usage code.
    typedef struct packed {
        logic       hit;
        logic [7:0] code;
    } ascii_map_t;

    function automatic logic is_mod_key(input logic [7:0] k);
        return k[7:3] == 5'b11100;
    endfunction

    function automatic logic [7:0] mod_bit(input logic [7:0] k);
        return 8'd1 << k[2:0];
    endfunction

    function automatic ascii_map_t map_ascii(input logic [7:0] c);
        ascii_map_t m;
        m.hit  = 1'b1;
        m.code = 8'h00;
        priority if (c == ASCII_LF || c == ASCII_CR) m.code = HID_ENTER;
        else if (c == ASCII_TAB) m.code = HID_TAB;
        else if (c == ASCII_BS)  m.code = HID_BKSP;
        else if (c == ASCII_ESC) m.code = HID_ESC;
        else if (c >= 8'h41 && c <= 8'h5A) m.code = (c - 8'h3D) | 8'h80;
        else if (c >= 8'h61 && c <= 8'h7A) m.code = c - 8'h5D;
        else if (c >= ASCII_PRINT_LO && c <= ASCII_PRINT_HI)
        begin
            unique case (c)
                8'h20: m.code = 8'h2C;
                8'h21: m.code = 8'h9E;
                8'h22: m.code = 8'hB4;
                8'h23: m.code = 8'hA0;
                8'h24: m.code = 8'hA1;
                8'h25: m.code = 8'hA2;
                8'h26: m.code = 8'hA4;
                8'h27: m.code = 8'h34;
                8'h28: m.code = 8'hA6;
                8'h29: m.code = 8'hA7;
                8'h2A: m.code = 8'hA5;
                8'h2B: m.code = 8'hAE;
                8'h2C: m.code = 8'h36;
                8'h2D: m.code = 8'h2D;
                8'h2E: m.code = 8'h37;
                8'h2F: m.code = 8'h38;
                8'h30: m.code = 8'h27;
                8'h31: m.code = 8'h1E;
                8'h32: m.code = 8'h1F;
                8'h33: m.code = 8'h20;
                8'h34: m.code = 8'h21;
                8'h35: m.code = 8'h22;
                8'h36: m.code = 8'h23;
                8'h37: m.code = 8'h24;
                8'h38: m.code = 8'h25;
                8'h39: m.code = 8'h26;
                8'h3A: m.code = 8'hB3;
                8'h3B: m.code = 8'h33;
                8'h3C: m.code = 8'hB6;
                8'h3D: m.code = 8'h2E;
                8'h3E: m.code = 8'hB7;
                8'h3F: m.code = 8'hB8;
                8'h40: m.code = 8'h9F;
                8'h5B: m.code = 8'h2F;
                8'h5C: m.code = 8'h31;
                8'h5D: m.code = 8'h30;
                8'h5E: m.code = 8'hA3;
                8'h5F: m.code = 8'hAD;
                8'h60: m.code = 8'h35;
                8'h7B: m.code = 8'hAF;
                8'h7C: m.code = 8'hB1;
                8'h7D: m.code = 8'hB0;
                8'h7E: m.code = 8'hB5;
                default: m.hit = 1'b0;
            endcase
        end
        else m.hit = 1'b0;
        return m;
    endfunction

endpackage

// ===== hw/rtl/hid_keyboard_report_builder.sv =====
// Keyboard report builder: modifier byte plus key slots, updated by press,
// release, release-all, clear, tap and type operations. Depends on hkrb_pkg.
//
//  channel | valid    | stall     | payload
//  --------+----------+-----------+---------------------------------------------
//  input   | in_valid | in_stall  | operation key_code extra_mods char_code link_ready
//  output  | out_valid| out_stall | mod_bits slot_a..slot_f last_report
//
// One item at a time. A press or release of a normal key walks the slots with a
// single comparator, one slot per cycle. A modifier press or release, or a
// release of all keys, skips the scan; a tap or type sends a press and then a
// release report. An item with no report returns to idle at once; an output stall
// holds the report. Reset clears the key and modifier state at once, but not the
// output registers; the block accepts items right after reset.
module hid_keyboard_report_builder
    import hkrb_pkg::*;
#(
    parameter int KEY_SLOTS = DEF_KEY_SLOTS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] operation,
    input  logic [7:0] key_code,
    input  logic [7:0] extra_mods,
    input  logic [7:0] char_code,
    input  logic       link_ready,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] mod_bits,
    output logic [7:0] slot_a,
    output logic [7:0] slot_b,
    output logic [7:0] slot_c,
    output logic [7:0] slot_d,
    output logic [7:0] slot_e,
    output logic [7:0] slot_f,
    output logic       last_report
);

    localparam int IDX_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam int OUT_N = (KEY_SLOTS < REPORT_SLOTS) ? KEY_SLOTS : REPORT_SLOTS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(KEY_SLOTS - 1);

    st_t              state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       key_reg, key_next;
    logic [7:0]       saved_reg, saved_next;
    logic [7:0]       held_reg, held_next;
    logic [7:0]       slots_reg [KEY_SLOTS];
    logic [7:0]       slots_next [KEY_SLOTS];
    logic             match_reg, match_next;
    logic             empty_found_reg, empty_found_next;
    logic [IDX_W-1:0] empty_idx_reg, empty_idx_next;
    logic             last_reg, last_next;
    logic [7:0]       out_mods_reg, out_mods_next;
    logic [7:0]       out_slot_reg [OUT_N];
    logic [7:0]       out_slot_next [OUT_N];
    logic             out_last_reg, out_last_next;

    logic             accepted;
    ascii_map_t       amap;
    logic [7:0]       tap_key;
    logic [7:0]       tap_mods;
    logic             do_add, do_rel, do_rall, do_clr, is_tap;
    logic [7:0]       scan_slot;
    logic             scan_hit, scan_zero, scan_end;
    logic [7:0]       slot_w [REPORT_SLOTS];

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_HOLD);
    assign accepted  = in_valid && !in_stall;

    // Operation decode; type is folded into tap with the mapped key.
    assign amap     = map_ascii(char_code);
    assign tap_key  = (operation == OP_TYPE) ? {1'b0, amap.code[6:0]} : key_code;
    assign tap_mods = (operation == OP_TYPE) ? (amap.code[7] ? LSHIFT_MOD : 8'h00)
                                             : extra_mods;
    assign do_add   = link_ready && (operation == OP_PRESS || operation == OP_TAP ||
                                     (operation == OP_TYPE && amap.hit));
    assign is_tap   = (operation != OP_PRESS);
    assign do_rall  = link_ready && (operation == OP_REL_ALL ||
                                     (operation == OP_RELEASE && key_code == 8'h00));
    assign do_rel   = link_ready && (operation == OP_RELEASE);
    assign do_clr   = (operation == OP_CLEAR);

    // The shared compare unit: one slot against the current key per cycle.
    assign scan_slot = slots_reg[idx_reg];
    assign scan_hit  = (scan_slot == key_reg);
    assign scan_zero = (scan_slot == 8'h00);
    assign scan_end  = (idx_reg == LAST_IDX);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accepted)
                begin
                    priority if (do_add)
                        state_next = is_mod_key(tap_key) ? ST_SEND : ST_SCAN_ADD;
                    else if (do_rall)
                        state_next = ST_SEND;
                    else if (do_rel)
                        state_next = is_mod_key(key_code) ? ST_SEND : ST_SCAN_DEL;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_SCAN_ADD,
            ST_SCAN_DEL:
            begin
                if (scan_end)
                    state_next = ST_SEND;
            end
            ST_SEND:
                state_next = ST_HOLD;
            ST_HOLD:
            begin
                if (!out_stall)
                begin
                    if (last_reg)
                        state_next = ST_IDLE;
                    else
                        state_next = is_mod_key(key_reg) ? ST_SEND : ST_SCAN_DEL;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        idx_next         = idx_reg;
        key_next         = key_reg;
        saved_next       = saved_reg;
        held_next        = held_reg;
        slots_next       = slots_reg;
        match_next       = match_reg;
        empty_found_next = empty_found_reg;
        empty_idx_next   = empty_idx_reg;
        last_next        = last_reg;
        out_mods_next    = out_mods_reg;
        out_slot_next    = out_slot_reg;
        out_last_next    = out_last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accepted)
                begin
                    key_next         = do_add ? tap_key : key_code;
                    saved_next       = held_reg;
                    idx_next         = '0;
                    match_next       = 1'b0;
                    empty_found_next = 1'b0;
                    empty_idx_next   = '0;
                    last_next        = !(do_add && is_tap);
                    priority if (do_clr || do_rall)
                    begin
                        held_next = 8'h00;
                        for (int i = 0; i < KEY_SLOTS; i++)
                            slots_next[i] = 8'h00;
                    end
                    else if (do_add)
                        held_next = held_reg | tap_mods |
                                    (is_mod_key(tap_key) ? mod_bit(tap_key) : 8'h00);
                    else if (do_rel && is_mod_key(key_code))
                        held_next = held_reg & ~mod_bit(key_code);
                    else
                        held_next = held_reg;
                end
            end
            ST_SCAN_ADD:
            begin
                if (scan_hit)
                    match_next = 1'b1;
                if (scan_zero && !empty_found_reg)
                begin
                    empty_found_next = 1'b1;
                    empty_idx_next   = idx_reg;
                end
                if (!scan_end)
                    idx_next = idx_reg + IDX_W'(1);
                // A key already held, or no free slot, leaves the slots alone.
                else if (!(match_reg || scan_hit) && (empty_found_reg || scan_zero))
                    slots_next[empty_found_reg ? empty_idx_reg : idx_reg] = key_reg;
            end
            ST_SCAN_DEL:
            begin
                if (scan_hit && !match_reg)
                begin
                    slots_next[idx_reg] = 8'h00;
                    match_next          = 1'b1;
                end
                if (!scan_end)
                    idx_next = idx_reg + IDX_W'(1);
            end
            ST_SEND:
            begin
                out_mods_next = held_reg;
                for (int j = 0; j < OUT_N; j++)
                    out_slot_next[j] = slots_reg[j];
                out_last_next = last_reg;
            end
            ST_HOLD:
            begin
                // Second half of a tap: the modifier byte returns to its
                // value from before the tap, and the key is released.
                if (!out_stall && !last_reg)
                begin
                    held_next  = saved_reg;
                    last_next  = 1'b1;
                    idx_next   = '0;
                    match_next = 1'b0;
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            idx_reg         <= '0;
            key_reg         <= 8'h00;
            saved_reg       <= 8'h00;
            held_reg        <= 8'h00;
            match_reg       <= 1'b0;
            empty_found_reg <= 1'b0;
            empty_idx_reg   <= '0;
            last_reg        <= 1'b0;
            for (int i = 0; i < KEY_SLOTS; i++)
                slots_reg[i] <= 8'h00;
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            key_reg         <= key_next;
            saved_reg       <= saved_next;
            held_reg        <= held_next;
            match_reg       <= match_next;
            empty_found_reg <= empty_found_next;
            empty_idx_reg   <= empty_idx_next;
            last_reg        <= last_next;
            slots_reg       <= slots_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_mods_reg <= out_mods_next;
        out_slot_reg <= out_slot_next;
        out_last_reg <= out_last_next;
    end

    for (genvar j = 0; j < REPORT_SLOTS; j++)
    begin : g_slot
        if (j < OUT_N)
        begin : g_used
            assign slot_w[j] = out_slot_reg[j];
        end
        else
        begin : g_unused
            assign slot_w[j] = 8'h00;
        end
    end

    assign mod_bits    = out_mods_reg;
    assign slot_a      = slot_w[0];
    assign slot_b      = slot_w[1];
    assign slot_c      = slot_w[2];
    assign slot_d      = slot_w[3];
    assign slot_e      = slot_w[4];
    assign slot_f      = slot_w[5];
    assign last_report = out_last_reg;

`ifndef SYNTHESIS
    a_busy_while_reporting: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("item accepted while a report is pending");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN_ADD || state_reg == ST_SCAN_DEL) |-> idx_reg <= LAST_IDX)
        else $error("slot scan index out of range");

    a_tap_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_report) |=> (in_stall && !out_valid))
        else $error("tap ended after its press report");
`endif

endmodule
